>>> rtl/wgm_pkg.sv
// shared types and constants for the wildcard glob matcher
package wgm_pkg;

	// command codes carried on the input tuser
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_NAME   = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	// wildcard bytes
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	// one input word after the input register
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] byte_value;
	} item_t;

	// one result word
	typedef struct packed {
		logic pattern_overflow;
		logic matched;
	} res_t;

endpackage

>>> rtl/wgm_in_reg.sv
// input register stage between the slave stream and the matcher core
module wgm_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wgm_pkg::item_t in_item,
	input  logic          adv,
	output logic          valid_s1,
	output wgm_pkg::item_t item_s1
);

	// stage takes a new word when empty or when its word moves on
	assign in_ready = !valid_s1 || adv;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/wgm_nfa.sv
// pattern store and active position set, updated once per word
module wgm_nfa #(
	parameter int PATTERN_MAX = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  wgm_pkg::item_t item,
	output wgm_pkg::res_t  res
);

	localparam int LENW = $clog2(PATTERN_MAX + 1);
	localparam int IDXW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [7:0]             store_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] star_q;
	logic [PATTERN_MAX-1:0] qmark_q;
	logic [PATTERN_MAX-1:0] mask_q;
	logic [LENW-1:0]        len_q;
	logic                   ovf_q;
	logic [PATTERN_MAX:0]   act_q;

	logic [PATTERN_MAX:0]   star_a;
	logic [PATTERN_MAX:0]   star_b;
	logic [PATTERN_MAX+1:0] star_sum;
	logic [PATTERN_MAX:0]   carry;
	logic [PATTERN_MAX:0]   closed;
	logic [PATTERN_MAX-1:0] stay;
	logic [PATTERN_MAX-1:0] step;
	logic [PATTERN_MAX:0]   nxt;
	logic [PATTERN_MAX:0]   start;
	logic                   full;
	logic [IDXW-1:0]        wr_idx;

	assign start  = (PATTERN_MAX + 1)'(1);
	assign full   = mask_q[PATTERN_MAX-1];
	assign wr_idx = len_q[IDXW-1:0];

	// star closure as a carry chain: stars propagate, active stars generate
	always_comb begin
		star_a   = {1'b0, star_q & mask_q};
		star_b   = star_a & act_q;
		star_sum = {1'b0, star_a} + {1'b0, star_b};
		carry    = star_sum[PATTERN_MAX:0] ^ star_a ^ star_b;
		closed   = act_q | carry;
	end

	// per-position lanes: star holds, literal or '?' steps forward
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			stay[i] = closed[i] & mask_q[i] & star_q[i];
			step[i] = closed[i] & mask_q[i] & ~star_q[i]
				& (qmark_q[i] | (store_q[i] == item.byte_value));
		end
		nxt = {1'b0, stay} | {step, 1'b0};
	end

	// end-of-name answer
	assign res.matched          = closed[len_q] & ~ovf_q;
	assign res.pattern_overflow = ovf_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			mask_q <= '0;
			ovf_q  <= 1'b0;
			act_q  <= (PATTERN_MAX + 1)'(1);
		end else if (fire) begin
			case (item.cmd)
				wgm_pkg::CMD_CLEAR: begin
					len_q  <= '0;
					mask_q <= '0;
					ovf_q  <= 1'b0;
					act_q  <= start;
				end
				wgm_pkg::CMD_APPEND: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						len_q  <= len_q + LENW'(1);
						mask_q <= (mask_q << 1) | PATTERN_MAX'(1);
					end
					act_q <= start;
				end
				wgm_pkg::CMD_NAME: begin
					act_q <= nxt;
				end
				default: begin
					act_q <= start;
				end
			endcase
		end
	end

	// pattern bytes and their wildcard marks
	always_ff @(posedge clk) begin
		if (fire && item.cmd == wgm_pkg::CMD_APPEND && !full) begin
			store_q[wr_idx] <= item.byte_value;
			star_q[wr_idx]  <= (item.byte_value == wgm_pkg::CH_STAR);
			qmark_q[wr_idx] <= (item.byte_value == wgm_pkg::CH_QMARK);
		end
	end

endmodule

>>> rtl/wgm_out_reg.sv
// result register feeding the master stream
module wgm_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  wgm_pkg::res_t res,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output wgm_pkg::res_t out_res
);

	assign free = !out_valid || out_ready;

	// word held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_res <= res;
		end
	end

endmodule

>>> rtl/wildcard_glob_matcher_unit.sv
// top level of the wildcard glob matcher
// Matches a streamed name against a stored wildcard pattern ('*' and '?').
// Slave stream: tuser carries the command (clear pattern, append pattern
// byte, name byte, end of name), tdata carries the byte. Pattern bytes are
// appended one per word; name bytes advance a set of active pattern
// positions, all positions updated in parallel.
// Master stream: one word per end-of-name command, with the match flag and
// the pattern overflow flag; other commands give no word.
// Flow: a word accepted into the input register is processed when it moves
// on from there, which also loads an end-of-name result into the result
// register; the master handshake follows from that register.
// Throughput is one word per cycle, set by the update of the active set
// (one star-closure add across PATTERN_MAX+1 positions), except that an
// end-of-name word waits while the result register is busy.
// Reset clears the pattern length, the overflow flag and the active set
// (start position only) and empties both registers; the pattern bytes are
// left as they are. When the receiver stalls, the result word is held, and
// the input stage stalls only when an end-of-name word would overwrite it.
module wildcard_glob_matcher_unit #(
	parameter int PATTERN_MAX = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] byte_value
	input  logic [1:0] s_axis_tuser,  // [1:0] command
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);

	wgm_pkg::item_t in_item;
	wgm_pkg::item_t item_s1;
	wgm_pkg::res_t  res;
	wgm_pkg::res_t  out_res;
	logic           valid_s1;
	logic           adv;
	logic           fire;
	logic           out_free;

	// pack the slave word
	assign in_item.cmd        = wgm_pkg::cmd_t'(s_axis_tuser);
	assign in_item.byte_value = s_axis_tdata;

	// a word moves on unless it is a result and the result register is busy
	assign adv  = (item_s1.cmd != wgm_pkg::CMD_END) || out_free;
	assign fire = valid_s1 && adv;

	wgm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wgm_nfa #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_nfa (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	wgm_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && item_s1.cmd == wgm_pkg::CMD_END),
		.res       (res),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// pack the master word
	assign m_axis_tdata = {6'd0, out_res.pattern_overflow, out_res.matched};

endmodule

>>> test/glob_match_checker.sv
// checker for the wildcard glob matcher: predicts verdicts and compares result words
`timescale 1ns / 1ps

module glob_match_checker
	import wgm_pkg::*;
#(
	parameter int PATTERN_MAX = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic [1:0] s_tuser,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	output int         fail_count,
	output int         verdicts_owed
);

	// shadow copy of the pattern and the live position set
	logic [7:0]           pat_bytes [PATTERN_MAX];
	int                   pat_len;
	logic [PATTERN_MAX:0] live_pos;
	logic                 pat_overflow;
	res_t                 pending_verdicts [$];
	int                   mismatches;

	// a live star position also makes the position after it live
	function automatic logic [PATTERN_MAX:0] spread_stars(input logic [PATTERN_MAX:0] pos);
		for (int i = 0; i < pat_len; i++) begin
			if (pos[i] && pat_bytes[i] == CH_STAR)
				pos[i + 1] = 1'b1;
		end
		return pos;
	endfunction

	// live set after one name byte
	function automatic logic [PATTERN_MAX:0] consume_byte(input logic [PATTERN_MAX:0] pos,
			input logic [7:0] b);
		logic [PATTERN_MAX:0] nxt;
		nxt = '0;
		pos = spread_stars(pos);
		for (int i = 0; i < pat_len; i++) begin
			if (pos[i]) begin
				if (pat_bytes[i] == CH_STAR)
					nxt[i] = 1'b1;
				else if (pat_bytes[i] == CH_QMARK || pat_bytes[i] == b)
					nxt[i + 1] = 1'b1;
			end
		end
		return nxt;
	endfunction

	// sample both channels at the edge, older result word first
	always @(posedge clk) begin
		res_t                 got;
		res_t                 want;
		logic [PATTERN_MAX:0] closed;
		if (!arst_n) begin
			pat_len = 0;
			pat_overflow = 1'b0;
			live_pos = (PATTERN_MAX + 1)'(1);
			mismatches = 0;
			pending_verdicts.delete();
			fail_count <= 0;
			verdicts_owed <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[1:0]);
				if (pending_verdicts.size() == 0) begin
					$error("result word with no verdict pending: tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					if (got.matched !== want.matched) begin
						$error("matched: expected %0b, actual %0b", want.matched, got.matched);
						mismatches++;
					end
					if (got.pattern_overflow !== want.pattern_overflow) begin
						$error("pattern_overflow: expected %0b, actual %0b",
							want.pattern_overflow, got.pattern_overflow);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (cmd_t'(s_tuser))
					CMD_CLEAR: begin
						pat_len = 0;
						pat_overflow = 1'b0;
						live_pos = (PATTERN_MAX + 1)'(1);
					end
					CMD_APPEND: begin
						if (pat_len < PATTERN_MAX) begin
							pat_bytes[pat_len] = s_tdata;
							pat_len++;
						end else begin
							pat_overflow = 1'b1;
						end
						live_pos = (PATTERN_MAX + 1)'(1);
					end
					CMD_NAME: begin
						live_pos = consume_byte(live_pos, s_tdata);
					end
					CMD_END: begin
						closed = spread_stars(live_pos);
						want.matched = !pat_overflow && closed[pat_len];
						want.pattern_overflow = pat_overflow;
						pending_verdicts.push_back(want);
						live_pos = (PATTERN_MAX + 1)'(1);
					end
				endcase
			end
			fail_count <= mismatches;
			verdicts_owed <= pending_verdicts.size();
		end
	end

endmodule

>>> test/tb_wildcard_glob_matcher_unit.sv
// testbench top for the wildcard glob matcher: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher_unit;
	import wgm_pkg::*;

	localparam int PATTERN_MAX = 32;
	localparam int RANDOM_WORDS = 650;
	localparam int CALM_WORDS = 80;
	localparam int CYCLE_LIMIT = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic [1:0] s_tuser = CMD_CLEAR;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	int          fail_count;
	int          verdicts_owed;
	int          words_sent = 0;
	int unsigned gap_odds = 0;
	logic        calm = 1'b0;
	int unsigned ready_left = 0;
	int unsigned cycles = 0;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	wildcard_glob_matcher_unit #(
		.PATTERN_MAX(PATTERN_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata)
	);

	glob_match_checker #(
		.PATTERN_MAX(PATTERN_MAX)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.verdicts_owed(verdicts_owed)
	);

	// mostly a small alphabet so literals collide often
	function automatic logic [7:0] pick_literal();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(8'h61, 8'h64));
		return 8'($urandom_range(1, 255));
	endfunction

	// offer one word, with an optional idle burst first, and wait for the handshake
	task automatic send_word(input cmd_t cmd, input logic [7:0] b);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	// receiver stalls in bursts, each followed by a ready stretch
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else if (m_tready && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			ready_left <= $urandom_range(0, 17);
		end else begin
			m_tready <= 1'b1;
			ready_left <= ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 18);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [7:0] pattern_q [$];
		logic [7:0] name_q [$];
		logic [7:0] b;
		int         len;
		int         idx;
		int         random_goal;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern: empty name matches, a nonempty one does not
		send_word(CMD_END, 8'h01);
		send_word(CMD_NAME, 8'h61);
		send_word(CMD_END, 8'hFF);
		// run of stars then a question mark: needs at least one byte
		send_word(CMD_CLEAR, 8'hFF);
		send_word(CMD_APPEND, CH_STAR);
		send_word(CMD_APPEND, CH_STAR);
		send_word(CMD_APPEND, CH_QMARK);
		send_word(CMD_END, 8'h55);
		send_word(CMD_NAME, 8'h01);
		send_word(CMD_END, 8'hAA);
		// extreme and zero bytes as literals
		send_word(CMD_CLEAR, 8'h80);
		send_word(CMD_APPEND, 8'hFF);
		send_word(CMD_APPEND, 8'h00);
		send_word(CMD_NAME, 8'hFF);
		send_word(CMD_NAME, 8'h00);
		send_word(CMD_END, 8'h7F);
		// appending restarts the name; literal mismatch after a partial name
		send_word(CMD_NAME, 8'hFF);
		send_word(CMD_APPEND, 8'h01);
		send_word(CMD_NAME, 8'hFF);
		send_word(CMD_NAME, 8'h00);
		send_word(CMD_NAME, 8'h02);
		send_word(CMD_END, 8'h00);

		// random patterns with names built to match, plus noise
		random_goal = words_sent + RANDOM_WORDS;
		while (words_sent < random_goal) begin
			if (words_sent >= random_goal - CALM_WORDS)
				calm = 1'b1;
			gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 6))
					send_word(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(1, 255)));
			end else begin
				case ($urandom_range(0, 19))
					0:       len = 0;
					1:       len = $urandom_range(PATTERN_MAX - 7, PATTERN_MAX + 4);
					default: len = $urandom_range(1, 8);
				endcase
				send_word(CMD_CLEAR, 8'($urandom_range(1, 255)));
				pattern_q.delete();
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 11))
						0, 1, 2: b = CH_STAR;
						3, 4:    b = CH_QMARK;
						default: b = pick_literal();
					endcase
					pattern_q.push_back(b);
					send_word(CMD_APPEND, b);
				end
				repeat ($urandom_range(1, 5)) begin
					name_q.delete();
					foreach (pattern_q[i]) begin
						if (pattern_q[i] == CH_STAR)
							repeat ($urandom_range(0, 3)) name_q.push_back(pick_literal());
						else if (pattern_q[i] == CH_QMARK)
							name_q.push_back(8'($urandom_range(1, 255)));
						else
							name_q.push_back(pattern_q[i]);
					end
					// break about a third of the names
					if ($urandom_range(0, 2) == 0) begin
						case ($urandom_range(0, 2))
							0: begin
								if (name_q.size() != 0) begin
									idx = $urandom_range(0, name_q.size() - 1);
									name_q[idx] = pick_literal();
								end
							end
							1: begin
								if (name_q.size() != 0) begin
									idx = $urandom_range(0, name_q.size() - 1);
									name_q.delete(idx);
								end
							end
							default: name_q.push_back(pick_literal());
						endcase
					end
					foreach (name_q[i])
						send_word(CMD_NAME, name_q[i]);
					send_word(CMD_END, 8'($urandom_range(1, 255)));
				end
			end
		end

		// drain and give the verdict
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (verdicts_owed != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
